[hw/rtl/dpp_pkg.sv]
// Shared types and constants for the dual PID to PWM compare block.
// No dependencies; every other file of the block depends on this package.
package dpp_pkg;

    localparam int MEAS_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int EN_W      = 3;
    localparam int CMP_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int ERR_W   = MEAS_W + 1;
    localparam int DEV_W   = ERR_W + 1;
    localparam int INTEG_W = 32;
    localparam int TP_W    = GAIN_W + 1 + ERR_W;
    localparam int TI_W    = GAIN_W + 1 + INTEG_W;
    localparam int TD_W    = GAIN_W + 1 + DEV_W;
    localparam int SUM_W   = TI_W + 2;

    localparam int SUM_LIMIT   = 100 << 20;
    localparam int OFF_W       = 28;
    localparam int DIV_SHIFT   = 23;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 29;
    localparam logic [RECIP_W-1:0] RECIP_M25 = 25'd21474837;
    localparam int CMP_MAX     = 511;

    localparam int NUM_STAGES = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_EN    = 3'd5;

    localparam int EN_P = 0;
    localparam int EN_I = 1;
    localparam int EN_D = 2;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

[hw/rtl/dpp_ifs.sv]
// Handshake interfaces for the measurement, compare and configuration channels.
// Depends on dpp_pkg for payload widths.
interface dpp_in_if;
    logic                        valid;
    logic                        ready;
    logic [dpp_pkg::MEAS_W-1:0]  measured_a;
    logic [dpp_pkg::MEAS_W-1:0]  measured_b;
    modport source (output valid, measured_a, measured_b, input ready);
    modport sink   (input valid, measured_a, measured_b, output ready);
endinterface

interface dpp_out_if;
    logic                        valid;
    logic                        ready;
    logic [dpp_pkg::CMP_W-1:0]   compare_a;
    logic [dpp_pkg::CMP_W-1:0]   compare_b;
    modport source (output valid, compare_a, compare_b, input ready);
    modport sink   (input valid, compare_a, compare_b, output ready);
endinterface

interface dpp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpp_pkg::CFG_IDX_W-1:0]  index;
    logic [dpp_pkg::CFG_DAT_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dpp_pipe_ctrl.sv]
// Stage valid bits and per-stage load strobes for the compare pipeline.
// Depends on dpp_pkg for the stage count and the control struct.
module dpp_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output dpp_pkg::t_pipe_ctl o_ctl
);
    import dpp_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_go;
    logic [NUM_STAGES-1:0] w_load;

    always_comb begin
        w_go[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_go[k] = !r_vld[k] || w_go[k+1];
        end
        w_load[0] = w_go[0] && i_in_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            w_load[k] = w_go[k] && r_vld[k-1];
        end
        n_vld[0] = w_go[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = w_go[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = w_go[0];
    assign o_ctl.load = w_load;
    assign o_ctl.vld  = r_vld;

endmodule

[hw/rtl/dpp_chan.sv]
// One PID channel: error, saturating integral, derivative, gated terms,
// clamp and mapping to a PWM compare value. Depends on dpp_pkg.
module dpp_chan #(
    parameter int COMPARE_SPAN = 500
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpp_pkg::t_pipe_ctl          i_ctl,
    input  logic [dpp_pkg::MEAS_W-1:0]  i_setpoint,
    input  logic [dpp_pkg::GAIN_W-1:0]  i_gain_p,
    input  logic [dpp_pkg::GAIN_W-1:0]  i_gain_i,
    input  logic [dpp_pkg::GAIN_W-1:0]  i_gain_d,
    input  logic [dpp_pkg::EN_W-1:0]    i_term_en,
    input  logic [dpp_pkg::MEAS_W-1:0]  i_measured,
    output logic [dpp_pkg::CMP_W-1:0]   o_compare
);
    import dpp_pkg::*;

    localparam int SPAN_W = $clog2(COMPARE_SPAN + 1);
    localparam int PROD_W = OFF_W + SPAN_W;
    localparam int X_W    = PROD_W - DIV_SHIFT;
    localparam int RP_W   = X_W + RECIP_W;
    localparam int Q_W    = RP_W - RECIP_SHIFT;
    localparam int QX_W   = (Q_W > CMP_W + 1) ? Q_W : CMP_W + 1;

    localparam logic signed [SUM_W-1:0]   LIM_POS = SUM_W'(SUM_LIMIT);
    localparam logic signed [SUM_W-1:0]   LIM_NEG = -SUM_W'(SUM_LIMIT);
    localparam logic signed [INTEG_W:0]   I_MAX   = (INTEG_W+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [INTEG_W:0]   I_MIN   = (INTEG_W+1)'(-33'sh0_8000_0000);

    logic [MEAS_W-1:0]          r_meas;

    logic signed [ERR_W-1:0]    r_err;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [DEV_W-1:0]    r_dev;
    logic signed [ERR_W-1:0]    n_err;
    logic signed [INTEG_W-1:0]  n_integ;
    logic signed [DEV_W-1:0]    n_dev;
    logic signed [INTEG_W:0]    w_integ_raw;

    logic signed [TP_W-1:0]     r_term_p;
    logic signed [TI_W-1:0]     r_term_i;
    logic signed [TD_W-1:0]     r_term_d;
    logic signed [GAIN_W:0]     w_gp;
    logic signed [GAIN_W:0]     w_gi;
    logic signed [GAIN_W:0]     w_gd;

    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_clamp;
    logic signed [SUM_W-1:0]    w_off_full;
    logic [OFF_W-1:0]           r_off;

    logic [PROD_W-1:0]          r_span_prod;
    logic [X_W-1:0]             w_x;
    logic [RP_W-1:0]            r_recip_prod;
    logic [QX_W-1:0]            w_q;
    logic [CMP_W-1:0]           r_cmp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_meas <= i_measured;
        end
    end

    always_comb begin
        n_err       = $signed({1'b0, i_setpoint}) - $signed({1'b0, r_meas});
        w_integ_raw = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(n_err);
        if (w_integ_raw > I_MAX) begin
            n_integ = INTEG_W'(I_MAX);
        end else if (w_integ_raw < I_MIN) begin
            n_integ = INTEG_W'(I_MIN);
        end else begin
            n_integ = INTEG_W'(w_integ_raw);
        end
        n_dev = DEV_W'(n_err) - DEV_W'(r_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_integ <= '0;
        end else if (i_ctl.load[1]) begin
            r_err   <= n_err;
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_dev <= n_dev;
        end
    end

    assign w_gp = $signed({1'b0, i_gain_p});
    assign w_gi = $signed({1'b0, i_gain_i});
    assign w_gd = $signed({1'b0, i_gain_d});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_term_p <= i_term_en[EN_P] ? TP_W'(w_gp * r_err)   : '0;
            r_term_i <= i_term_en[EN_I] ? TI_W'(w_gi * r_integ) : '0;
            r_term_d <= i_term_en[EN_D] ? TD_W'(w_gd * r_dev)   : '0;
        end
    end

    always_comb begin
        w_sum = SUM_W'(r_term_p) + SUM_W'(r_term_i) + SUM_W'(r_term_d);
        if (w_sum > LIM_POS) begin
            w_clamp = LIM_POS;
        end else if (w_sum < LIM_NEG) begin
            w_clamp = LIM_NEG;
        end else begin
            w_clamp = w_sum;
        end
        w_off_full = w_clamp + LIM_POS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_off <= w_off_full[OFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_span_prod <= PROD_W'(r_off) * PROD_W'(COMPARE_SPAN);
        end
    end

    assign w_x = r_span_prod[PROD_W-1:DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_recip_prod <= RP_W'(w_x) * RP_W'(RECIP_M25);
        end
    end

    assign w_q = QX_W'(r_recip_prod[RP_W-1:RECIP_SHIFT]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r_cmp <= (w_q > QX_W'(CMP_MAX)) ? CMP_W'(CMP_MAX) : w_q[CMP_W-1:0];
        end
    end

    assign o_compare = r_cmp;

endmodule

[hw/rtl/dual_pid_pwm_duty_unit.sv]
// Top level of the dual PID to PWM compare block: configuration registers,
// pipeline control and two channel datapaths.
// Depends on dpp_pkg, dpp_ifs, dpp_pipe_ctrl and dpp_chan.
//
// Usage:
//   i_meas carries one control tick (measured_a, measured_b, Q4.12 volts).
//   o_cmp returns one item per tick: compare_a and compare_b, 250 is zero
//   drive at the default span of 500.
//   i_cfg writes one register per handshake: 0 setpoint_a, 1 setpoint_b,
//   2 gain_p, 3 gain_i, 4 gain_d, 5 term_enables; other indexes are dropped.
//   Write configuration only while no tick is in flight.
// Timing:
//   Seven register stages. One tick per cycle is sustained while o_cmp is not
//   held: the integral and last error update together in the error stage,
//   which sets the rate.
// Reset:
//   Registers return to their defaults, both integrals and last errors clear,
//   the pipeline empties.
// Stall:
//   While o_cmp is held, stages keep filling bubbles; i_meas.ready drops only
//   when all seven stages hold an item.
module dual_pid_pwm_duty_unit #(
    parameter int COMPARE_SPAN = 500
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpp_in_if.sink     i_meas,
    dpp_cfg_if.sink    i_cfg,
    dpp_out_if.source  o_cmp
);
    import dpp_pkg::*;

    localparam int CMP_CAP = (COMPARE_SPAN < CMP_MAX) ? COMPARE_SPAN : CMP_MAX;

    logic [MEAS_W-1:0] r_setpoint_a;
    logic [MEAS_W-1:0] r_setpoint_b;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [EN_W-1:0]   r_term_en;

    t_pipe_ctl         w_ctl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint_a <= 16'd9667;
            r_setpoint_b <= 16'd7209;
            r_gain_p     <= 16'd28160;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_term_en    <= 3'd7;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SETPOINT_A: r_setpoint_a <= i_cfg.data;
                REG_SETPOINT_B: r_setpoint_b <= i_cfg.data;
                REG_GAIN_P:     r_gain_p     <= i_cfg.data;
                REG_GAIN_I:     r_gain_i     <= i_cfg.data;
                REG_GAIN_D:     r_gain_d     <= i_cfg.data;
                REG_TERM_EN:    r_term_en    <= i_cfg.data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    dpp_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_meas.valid),
        .i_out_ready (o_cmp.ready),
        .o_in_ready  (i_meas.ready),
        .o_ctl       (w_ctl)
    );

    dpp_chan #(
        .COMPARE_SPAN (COMPARE_SPAN)
    ) u_chan_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_setpoint (r_setpoint_a),
        .i_gain_p   (r_gain_p),
        .i_gain_i   (r_gain_i),
        .i_gain_d   (r_gain_d),
        .i_term_en  (r_term_en),
        .i_measured (i_meas.measured_a),
        .o_compare  (o_cmp.compare_a)
    );

    dpp_chan #(
        .COMPARE_SPAN (COMPARE_SPAN)
    ) u_chan_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_setpoint (r_setpoint_b),
        .i_gain_p   (r_gain_p),
        .i_gain_i   (r_gain_i),
        .i_gain_d   (r_gain_d),
        .i_term_en  (r_term_en),
        .i_measured (i_meas.measured_b),
        .o_compare  (o_cmp.compare_b)
    );

    assign o_cmp.valid = w_ctl.vld[NUM_STAGES-1];

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_meas.ready |-> (&w_ctl.vld))
        else $error("input stalled with a free pipeline stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cmp.valid)
        else $error("result valid right after reset");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmp.valid |-> (32'(o_cmp.compare_a) <= CMP_CAP) && (32'(o_cmp.compare_b) <= CMP_CAP))
        else $error("compare value beyond span");

    a_load_sets_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load[0] |=> w_ctl.vld[0])
        else $error("accepted item did not enter the first stage");
`endif

endmodule
